// ----- sv/wgc_pkg.sv -----
// Package for the weighted group collapse block.
// Holds field widths, input kind codes, controller states and the command/status structs.
// No dependencies.
package wgc_pkg;

	localparam int VAL_W  = 32;
	localparam int VSUM_W = 64;
	localparam int WSUM_W = 48;
	localparam int CNT_W  = 10;
	localparam int KIND_W = 2;
	localparam int DIV_CNT_W = 6;

	typedef enum logic [KIND_W-1:0] {
		KIND_FINE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ACC,
		S_CLOSE,
		S_DIV,
		S_FIX,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic acc;
		logic close;
		logic div_step;
		logic fix;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic raw;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ----- sv/weighted_group_collapse_core.sv -----
// Top level of the weighted group collapse block.
// Joins the controller (wgc_ctrl) and the datapath (wgc_dp); depends on wgc_pkg.
//
// Input channel: in_valid/in_stall with kind, sample_value, flux_weight. kind 0 adds a
// fine group to the running sums, kind 1 adds one and closes the coarse group, kind 2
// closes the coarse group without adding, kind 3 is dropped.
// Output channel: out_valid/out_stall with collapsed_value, coarse_index, unnormalized,
// saturated; one beat per closed coarse group.
// Configuration: cfg_we/cfg_wdata writes normalize_enable (reset 1); write it only idle.
// Sequencing: the block works on one item at a time. A fine group is multiplied, then
// accumulated. A close then goes to the emit step when the raw sum is emitted, or,
// when the mean is taken, the radix-2 divider retires one quotient bit per cycle over
// 64 bits and a rounding step runs. The result beat shows the cycle after the emit.
// The output register parts the two sides: the next item is accepted while a result
// waits. When out_stall holds a result, the next close waits in its emit step and
// in_stall stays high until the output register frees.
// Reset clears the sums, the group counter and the output valid, and sets normalize on.
module weighted_group_collapse_core #(
	parameter int unsigned MAX_COARSE_GROUPS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [wgc_pkg::KIND_W-1:0]         kind,
	input  logic signed [wgc_pkg::VAL_W-1:0]   sample_value,
	input  logic signed [wgc_pkg::VAL_W-1:0]   flux_weight,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [wgc_pkg::VAL_W-1:0]   collapsed_value,
	output logic [wgc_pkg::CNT_W-1:0]          coarse_index,
	output logic                               unnormalized,
	output logic                               saturated
);
	import wgc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	wgc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	wgc_dp #(
		.MAX_COARSE_GROUPS (MAX_COARSE_GROUPS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample_value    (sample_value),
		.flux_weight     (flux_weight),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.collapsed_value (collapsed_value),
		.coarse_index    (coarse_index),
		.unnormalized    (unnormalized),
		.saturated       (saturated)
	);

endmodule

// ----- sv/wgc_ctrl.sv -----
// Controller for the weighted group collapse block.
// Sequences accept, accumulate, close, divide, round and emit; drives the datapath by commands.
// Depends on wgc_pkg.
module wgc_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [wgc_pkg::KIND_W-1:0]  kind,
	output logic                        in_stall,
	output wgc_pkg::cmd_t               cmd,
	input  wgc_pkg::sts_t               sts
);
	import wgc_pkg::*;

	state_t state_q, state_d;
	logic   close_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			close_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				close_q <= (kind_t'(kind) == KIND_CLOSE);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					case (kind_t'(kind))
						KIND_FINE, KIND_CLOSE: state_d = S_ACC;
						KIND_EMPTY:            state_d = S_CLOSE;
						default:               state_d = S_IDLE;
					endcase
				end
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = close_q ? S_CLOSE : S_IDLE;
			end
			S_CLOSE: begin
				cmd.close = 1'b1;
				state_d   = sts.raw ? S_EMIT : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_FIX;
				end
			end
			S_FIX: begin
				cmd.fix = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- sv/wgc_dp.sv -----
// Datapath for the weighted group collapse block.
// Multiplier, saturating sums, rounding, radix-2 divider, group counter and output register.
// Depends on wgc_pkg.
module wgc_dp #(
	parameter int unsigned MAX_COARSE_GROUPS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wgc_pkg::cmd_t                     cmd,
	output wgc_pkg::sts_t                     sts,
	input  logic signed [wgc_pkg::VAL_W-1:0]  sample_value,
	input  logic signed [wgc_pkg::VAL_W-1:0]  flux_weight,
	input  logic                              cfg_we,
	input  logic                              cfg_wdata,
	input  logic                              out_stall,
	output logic                              out_valid,
	output logic signed [wgc_pkg::VAL_W-1:0]  collapsed_value,
	output logic [wgc_pkg::CNT_W-1:0]         coarse_index,
	output logic                              unnormalized,
	output logic                              saturated
);
	import wgc_pkg::*;

	localparam int unsigned CNT_SPAN = 1 << CNT_W;
	localparam int unsigned WRAP =
		(MAX_COARSE_GROUPS < CNT_SPAN) ? MAX_COARSE_GROUPS : CNT_SPAN;
	localparam logic [CNT_W-1:0] GRP_LAST = CNT_W'(WRAP - 1);

	localparam logic signed [VSUM_W-1:0] VSUM_MAX = {1'b0, {(VSUM_W-1){1'b1}}};
	localparam logic signed [VSUM_W-1:0] VSUM_MIN = {1'b1, {(VSUM_W-1){1'b0}}};
	localparam logic signed [WSUM_W-1:0] WSUM_MAX = {1'b0, {(WSUM_W-1){1'b1}}};
	localparam logic signed [WSUM_W-1:0] WSUM_MIN = {1'b1, {(WSUM_W-1){1'b0}}};
	localparam logic [VAL_W-1:0] RES_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] RES_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [VSUM_W-1:0] QMAX_POS = {{(VSUM_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
	localparam logic [VSUM_W-1:0] QMAX_NEG = QMAX_POS + 64'd1;
	localparam int RAW_W = VSUM_W - 16 + 1;

	logic                      norm_q;
	logic signed [VSUM_W-1:0]  prod_s1;
	logic signed [VAL_W-1:0]   wt_s1;
	logic signed [VSUM_W-1:0]  vsum_q;
	logic signed [WSUM_W-1:0]  wsum_q;
	logic                      clip_q;
	logic [CNT_W-1:0]          grp_q;
	logic [VAL_W-1:0]          res_q;
	logic                      raw_q;
	logic                      rclip_q;
	logic                      neg_q;
	logic [VSUM_W-1:0]         quo_q;
	logic [WSUM_W-1:0]         rem_q;
	logic [WSUM_W-1:0]         den_q;
	logic [DIV_CNT_W-1:0]      dcnt_q;
	logic                      out_valid_q;
	logic [VAL_W-1:0]          out_value_q;
	logic [CNT_W-1:0]          out_index_q;
	logic                      out_raw_q;
	logic                      out_sat_q;

	logic [VSUM_W:0]           vsum_wide;
	logic                      vsum_ovf;
	logic signed [VSUM_W-1:0]  vsum_nx;
	logic [WSUM_W:0]           wsum_wide;
	logic                      wsum_ovf;
	logic signed [WSUM_W-1:0]  wsum_nx;
	logic                      raw_now;
	logic [RAW_W-1:0]          raw_q_wide;
	logic                      raw_ok;
	logic [VAL_W-1:0]          raw_res;
	logic [VSUM_W-1:0]         vmag;
	logic [WSUM_W-1:0]         wmag;
	logic [WSUM_W:0]           rem_sh;
	logic [WSUM_W:0]           trial;
	logic                      ge;
	logic                      round_up;
	logic [VSUM_W-1:0]         qr;
	logic                      fix_clip;
	logic [VAL_W-1:0]          fix_res;

	always_comb begin
		vsum_wide = {prod_s1[VSUM_W-1], prod_s1} + {vsum_q[VSUM_W-1], vsum_q};
		vsum_ovf  = vsum_wide[VSUM_W] ^ vsum_wide[VSUM_W-1];
		vsum_nx   = vsum_ovf ? (vsum_wide[VSUM_W] ? VSUM_MIN : VSUM_MAX)
		                     : signed'(vsum_wide[VSUM_W-1:0]);

		wsum_wide = {wsum_q[WSUM_W-1], wsum_q}
		          + {{(WSUM_W-VAL_W+1){wt_s1[VAL_W-1]}}, wt_s1};
		wsum_ovf  = wsum_wide[WSUM_W] ^ wsum_wide[WSUM_W-1];
		wsum_nx   = wsum_ovf ? (wsum_wide[WSUM_W] ? WSUM_MIN : WSUM_MAX)
		                     : signed'(wsum_wide[WSUM_W-1:0]);

		raw_now = !norm_q || (wsum_q == '0);

		raw_q_wide = {vsum_q[VSUM_W-1], vsum_q[VSUM_W-1:16]}
		           + {{(RAW_W-1){1'b0}}, vsum_q[15]};
		raw_ok  = (raw_q_wide[RAW_W-1:VAL_W-1] == '0)
		       || (raw_q_wide[RAW_W-1:VAL_W-1] == '1);
		raw_res = raw_ok ? raw_q_wide[VAL_W-1:0]
		                 : (raw_q_wide[RAW_W-1] ? RES_MIN : RES_MAX);

		vmag = vsum_q[VSUM_W-1] ? (VSUM_W'(0) - vsum_q) : vsum_q;
		wmag = wsum_q[WSUM_W-1] ? (WSUM_W'(0) - wsum_q) : wsum_q;

		rem_sh = {rem_q, quo_q[VSUM_W-1]};
		trial  = rem_sh - {1'b0, den_q};
		ge     = !trial[WSUM_W];

		round_up = ({rem_q, 1'b0} >= {1'b0, den_q});
		qr       = quo_q + {{(VSUM_W-1){1'b0}}, round_up};
		if (neg_q) begin
			fix_clip = (qr > QMAX_NEG);
			fix_res  = fix_clip ? RES_MIN : (VAL_W'(0) - qr[VAL_W-1:0]);
		end else begin
			fix_clip = (qr > QMAX_POS);
			fix_res  = fix_clip ? RES_MAX : qr[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_s1 <= sample_value * flux_weight;
			wt_s1   <= flux_weight;
		end
		if (cmd.close) begin
			raw_q <= raw_now;
			if (raw_now) begin
				res_q   <= raw_res;
				rclip_q <= !raw_ok;
			end else begin
				quo_q   <= vmag;
				rem_q   <= '0;
				den_q   <= wmag;
				neg_q   <= vsum_q[VSUM_W-1] ^ wsum_q[WSUM_W-1];
				rclip_q <= 1'b0;
			end
		end
		if (cmd.div_step) begin
			rem_q <= ge ? trial[WSUM_W-1:0] : rem_sh[WSUM_W-1:0];
			quo_q <= {quo_q[VSUM_W-2:0], ge};
		end
		if (cmd.fix) begin
			res_q   <= fix_res;
			rclip_q <= fix_clip;
		end
		if (cmd.emit) begin
			out_value_q <= res_q;
			out_index_q <= grp_q;
			out_raw_q   <= raw_q;
			out_sat_q   <= clip_q | rclip_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_q      <= 1'b1;
			vsum_q      <= '0;
			wsum_q      <= '0;
			clip_q      <= 1'b0;
			grp_q       <= '0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				norm_q <= cfg_wdata;
			end
			if (cmd.acc) begin
				vsum_q <= vsum_nx;
				wsum_q <= wsum_nx;
				clip_q <= clip_q | vsum_ovf | wsum_ovf;
			end else if (cmd.emit) begin
				vsum_q <= '0;
				wsum_q <= '0;
				clip_q <= 1'b0;
			end
			if (cmd.emit) begin
				grp_q <= (grp_q == GRP_LAST) ? '0 : grp_q + CNT_W'(1);
			end
			if (cmd.close) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + DIV_CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.raw      = raw_now;
	assign sts.div_done = (dcnt_q == '1);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid       = out_valid_q;
	assign collapsed_value = signed'(out_value_q);
	assign coarse_index    = out_index_q;
	assign unnormalized    = out_raw_q;
	assign saturated       = out_sat_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit while output register busy");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (vsum_q == '0) && (wsum_q == '0) && !clip_q)
		else $error("sums not cleared after emit");

	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close && !sts.raw |=> (den_q != '0))
		else $error("divide started with zero divisor");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < den_q))
		else $error("partial remainder not below divisor");

endmodule
